// ----- sv/ffba_pkg.sv -----
package ffba_pkg;

  // Table size and derived widths
  localparam int unsigned MAX_BLOCKS = 64;
  localparam int unsigned IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Field widths
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned LIMIT_W  = 21;
  localparam int unsigned HDR_W    = 8;
  localparam int unsigned STATUS_W = 3;

  // Heap capacity; larger limits saturate here
  localparam logic [LIMIT_W-1:0] HEAP_CAP = LIMIT_W'(1048576);

  // Configuration register indexes
  localparam logic REG_HEAP_LIMIT  = 1'b0;
  localparam logic REG_HEADER_SIZE = 1'b1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_REUSED  = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NEW     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_OOM     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_UNKNOWN = 3'd4;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GROW,
    S_OUT
  } ffba_state_e;

  // One block table entry
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              free;
  } ffba_entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic commit_hit;
    logic commit_miss;
    logic grow;
    logic load_out;
  } ffba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
    logic kind;
  } ffba_sts_t;

endpackage

// ----- sv/first_fit_block_allocator_core.sv -----
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata alloc_bytes, free_address; tuser kind
// m_axis    out        m_axis_tvalid/tready        tdata payload_address, status
// cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// Each item first runs the first-fit scan, which reads the block table through its
// single registered read port, one entry per cycle, over the valid entries up to the
// first match; an allocate that misses then goes on to the growth test.
// Reset clears the entry count and heap top; table contents need no clearing.
// A finished result waits in the output register while the next item is accepted.
module first_fit_block_allocator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [39:0]                          s_axis_tdata,  // alloc_bytes, free_address
  input  logic                                 s_axis_tuser,  // kind
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // payload_address, status, pad
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_index_i,
  input  logic [ffba_pkg::LIMIT_W-1:0]         cfg_data_i
);
  import ffba_pkg::*;

  ffba_cmd_t           cmd;
  ffba_sts_t           sts;
  logic [ADDR_W-1:0]   payload_address;
  logic [STATUS_W-1:0] status;

  assign cfg_ready_o = 1'b1;

  // Controller
  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with the block table
  ffba_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (s_axis_tuser),
    .alloc_bytes_i     (s_axis_tdata[19:0]),
    .free_address_i    (s_axis_tdata[39:20]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .payload_address_o (payload_address),
    .status_o          (status)
  );

  assign m_axis_tdata = {1'b0, status, payload_address};

`ifndef NO_ASSERTIONS
  // One item at a time: after an accept the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[22:20] <= STS_UNKNOWN))
    else $error("undefined status code");

  // Failures and frees carry a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[22:20] == STS_OOM || m_axis_tdata[22:20] == STS_FREED ||
                      m_axis_tdata[22:20] == STS_UNKNOWN) |-> (m_axis_tdata[19:0] == '0))
    else $error("nonzero address with a non-grant status");
`endif

endmodule

// ----- sv/ffba_ctrl.sv -----
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_cmd_t cmd_o
);
  import ffba_pkg::*;

  ffba_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.commit_hit = 1'b1;
          state_d          = S_OUT;
        end else if (sts_i.scan_end) begin
          if (sts_i.kind == KIND_FREE) begin
            cmd_o.commit_miss = 1'b1;
            state_d           = S_OUT;
          end else begin
            state_d = S_GROW;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_GROW: begin
        cmd_o.grow = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ffba_dp.sv -----
module ffba_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ffba_pkg::ffba_cmd_t                   cmd_i,
  output ffba_pkg::ffba_sts_t                   sts_o,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_index_i,
  input  logic [ffba_pkg::LIMIT_W-1:0]          cfg_data_i,
  input  logic                                  kind_i,
  input  logic [ffba_pkg::ADDR_W-1:0]           alloc_bytes_i,
  input  logic [ffba_pkg::ADDR_W-1:0]           free_address_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [ffba_pkg::ADDR_W-1:0]           payload_address_o,
  output logic [ffba_pkg::STATUS_W-1:0]         status_o
);
  import ffba_pkg::*;

  // Block table memory
  ffba_entry_t mem [MAX_BLOCKS];

  logic [LIMIT_W-1:0]  limit_q;
  logic [HDR_W-1:0]    hdr_q;
  logic [CNT_W-1:0]    count_q;
  logic [LIMIT_W-1:0]  top_q;
  logic                kind_q;
  logic [ADDR_W-1:0]   req_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [LIMIT_W-1:0]  payload_q;
  logic [CNT_W-1:0]    ptr_q;
  logic                vld_q;
  logic [IDX_W-1:0]    chk_q;
  ffba_entry_t         rd_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [STATUS_W-1:0] out_status_q;

  logic                rd_en;
  logic                match;
  logic                we;
  logic [IDX_W-1:0]    wa;
  ffba_entry_t         wd;
  logic [LIMIT_W:0]    end_w;
  logic [LIMIT_W-1:0]  limit_eff;
  logic                oom;
  logic                table_full;

  // Compare of the entry read last cycle against the pending request
  always_comb begin
    if (kind_q == KIND_FREE) begin
      match = (rd_q.base == addr_q);
    end else begin
      match = rd_q.free && (rd_q.size >= req_q);
    end
  end

  assign rd_en          = cmd_i.scan && (ptr_q != count_q);
  assign sts_o.hit      = vld_q && match;
  assign sts_o.scan_end = (ptr_q == count_q) && !(vld_q && match);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.kind     = kind_q;

  // Growth test for a new block at the heap top
  assign end_w      = {1'b0, payload_q} + {2'b00, req_q};
  assign limit_eff  = (limit_q > HEAP_CAP) ? HEAP_CAP : limit_q;
  assign table_full = (count_q == CNT_W'(MAX_BLOCKS));
  assign oom        = table_full || (end_w > {1'b0, limit_eff}) || payload_q[ADDR_W];

  // Table write select
  always_comb begin
    we      = 1'b0;
    wa      = chk_q;
    wd      = rd_q;
    wd.free = kind_q;
    if (cmd_i.commit_hit) begin
      we = 1'b1;
    end else if (cmd_i.grow && !oom) begin
      we      = 1'b1;
      wa      = count_q[IDX_W-1:0];
      wd.base = payload_q[ADDR_W-1:0];
      wd.size = req_q;
      wd.free = 1'b0;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= HEAP_CAP;
      hdr_q   <= HDR_W'(24);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_HEAP_LIMIT) begin
        limit_q <= cfg_data_i;
      end else begin
        hdr_q <= cfg_data_i[HDR_W-1:0];
      end
    end
  end

  // Heap state and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      top_q   <= '0;
      ptr_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= rd_en;
      if (cmd_i.start) begin
        ptr_q <= '0;
      end else if (rd_en) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (cmd_i.grow && !oom) begin
        count_q <= count_q + CNT_W'(1);
        top_q   <= end_w[LIMIT_W-1:0];
      end
    end
  end

  // Request latch and scan position
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q    <= kind_i;
      req_q     <= alloc_bytes_i;
      addr_q    <= free_address_i;
      payload_q <= top_q + {{(LIMIT_W-HDR_W){1'b0}}, hdr_q};
    end
    if (rd_en) begin
      chk_q <= ptr_q[IDX_W-1:0];
    end
  end

  // Result of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_hit) begin
      res_addr_q   <= (kind_q == KIND_FREE) ? '0 : rd_q.base;
      res_status_q <= (kind_q == KIND_FREE) ? STS_FREED : STS_REUSED;
    end else if (cmd_i.commit_miss) begin
      res_addr_q   <= '0;
      res_status_q <= STS_UNKNOWN;
    end else if (cmd_i.grow) begin
      res_addr_q   <= oom ? '0 : payload_q[ADDR_W-1:0];
      res_status_q <= oom ? STS_OOM : STS_NEW;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign payload_address_o = out_addr_q;
  assign status_o          = out_status_q;

endmodule
